[design/rbc_pkg.sv]
// Package with shared types, codes and widths for the reconnect backoff controller.
`timescale 1ns / 1ps
`default_nettype none
package rbc_pkg;

  localparam int unsigned DelayBits = 24;
  localparam int unsigned CountBits = 32;
  localparam int unsigned ProdBits  = DelayBits + 8;
  localparam int unsigned SumBits   = 40;
  localparam int unsigned TickBits  = 32;
  localparam int unsigned MeanBits  = 32;
  localparam int unsigned CfgIdxBits = 3;
  localparam int unsigned CfgDataBits = 24;
  localparam int unsigned DivCntBits = 6;

  localparam logic [2:0] FuncTick      = 3'd0;
  localparam logic [2:0] FuncState     = 3'd1;
  localparam logic [2:0] FuncNet       = 3'd2;
  localparam logic [2:0] FuncStart     = 3'd3;
  localparam logic [2:0] FuncCancel    = 3'd4;
  localparam logic [2:0] FuncReconn    = 3'd5;

  localparam logic [2:0] LsConnected    = 3'd1;
  localparam logic [2:0] LsDisconnected = 3'd2;
  localparam logic [2:0] LsReconnecting = 3'd3;
  localparam logic [2:0] LsFailed       = 3'd4;

  localparam logic [2:0] EvNone   = 3'd0;
  localparam logic [2:0] EvDisc   = 3'd1;
  localparam logic [2:0] EvRecon  = 3'd2;
  localparam logic [2:0] EvDone   = 3'd3;
  localparam logic [2:0] EvFailed = 3'd4;
  localparam logic [2:0] EvIce    = 3'd5;

  localparam logic [1:0] StratNone      = 2'd0;
  localparam logic [1:0] StratImmediate = 2'd1;
  localparam logic [1:0] StratLinear    = 2'd2;
  localparam logic [1:0] StratExp       = 2'd3;

  localparam logic [CfgIdxBits-1:0] RegStrategy = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegInitial  = 3'd1;
  localparam logic [CfgIdxBits-1:0] RegMax      = 3'd2;
  localparam logic [CfgIdxBits-1:0] RegFactor   = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegLimit    = 3'd4;
  localparam logic [CfgIdxBits-1:0] RegIce      = 3'd5;

  typedef struct packed {
    logic [2:0] func;
    logic [2:0] new_link_state;
    logic       net_up;
  } in_t;

  typedef struct packed {
    logic [2:0]           event_res;
    logic [7:0]           attempt_count;
    logic [2:0]           link_state;
    logic                 recov_active;
    logic                 start_accepted;
    logic [DelayBits-1:0] next_delay_ms;
    logic [CountBits-1:0] disconnect_total;
    logic [CountBits-1:0] success_total;
    logic [CountBits-1:0] failure_total;
    logic [CountBits-1:0] ice_restart_total;
    logic [SumBits-1:0]   downtime_total_ms;
    logic [MeanBits-1:0]  mean_recovery_ms;
  } out_t;

  typedef struct packed {
    logic [1:0]           strategy;
    logic [15:0]          initial_delay_ms;
    logic [DelayBits-1:0] max_delay_ms;
    logic [11:0]          backoff_factor;
    logic [7:0]           attempt_limit;
    logic                 ice_restart_enable;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic step;      // run the event logic on the held item
    logic mul;       // register the growth multiply
    logic div_start; // load the divider
    logic div_step;  // one restoring division step
    logic div_done;  // store the mean
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_mul;  // attempt advances, growth product must be updated
    logic need_div;  // success, mean must be recomputed
    logic div_last;  // last division step
  } sts_t;

endpackage
`default_nettype wire

[design/rbc_if.sv]
// Valid/ready channel interface used for the item and result streams.
`timescale 1ns / 1ps
`default_nettype none
interface rbc_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

[design/rbc_ctrl.sv]
// Controller state machine sequencing event, multiply and divide steps.
`timescale 1ns / 1ps
`default_nettype none
module rbc_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire rbc_pkg::sts_t sts_i,
  output rbc_pkg::cmd_t      cmd_o
);
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StEval = 3'd1;
  localparam logic [2:0] StMul  = 3'd2;
  localparam logic [2:0] StDivL = 3'd3;
  localparam logic [2:0] StDiv  = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  logic [2:0] state_q, state_d;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StEval;
      end
      StEval: begin
        // Multiply first so the next attempt sees the new product.
        if (sts_i.need_mul) begin
          cmd_o.mul = 1'b1;
          state_d   = StMul;
        end else begin
          cmd_o.step = 1'b1;
          state_d    = sts_i.need_div ? StDivL : StOut;
        end
      end
      StMul: begin
        cmd_o.step = 1'b1;
        state_d    = StOut;
      end
      StDivL: begin
        cmd_o.div_start = 1'b1;
        state_d         = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          cmd_o.div_done = 1'b1;
          state_d        = StOut;
        end
      end
      StOut: begin
        if (out_ready_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else state_q <= state_d;
  end
endmodule
`default_nettype wire

[design/rbc_dp.sv]
// Datapath: link state, attempt and delay registers, counters and mean divider.
`timescale 1ns / 1ps
`default_nettype none
module rbc_dp (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  load_i,
  input  wire rbc_pkg::in_t                          item_i,
  input  wire logic                                  cfg_we_i,
  input  wire logic [rbc_pkg::CfgIdxBits-1:0]        cfg_idx_i,
  input  wire logic [rbc_pkg::CfgDataBits-1:0]       cfg_data_i,
  input  wire rbc_pkg::cmd_t                         cmd_i,
  output rbc_pkg::sts_t                              sts_o,
  output rbc_pkg::out_t                              res_o
);
  localparam int unsigned DB = rbc_pkg::DelayBits;
  localparam int unsigned PB = rbc_pkg::ProdBits;
  localparam int unsigned CB = rbc_pkg::CountBits;
  localparam int unsigned SB = rbc_pkg::SumBits;
  localparam int unsigned TB = rbc_pkg::TickBits;
  localparam int unsigned MB = rbc_pkg::MeanBits;
  localparam int unsigned NB = rbc_pkg::DivCntBits;

  rbc_pkg::cfg_t cfg_q;
  rbc_pkg::in_t  item_q;

  logic [2:0]    link_q, link_d;
  logic          rec_q, rec_d;
  logic [7:0]    att_q, att_d;
  logic [DB-1:0] delay_q, delay_d;
  logic [DB-1:0] rem_q, rem_d;
  logic [PB-1:0] prod_q, prod_d;
  logic [PB-1:0] newprod_q;
  logic [TB-1:0] down_q, down_d;
  logic [CB-1:0] disc_q, disc_d, succ_q, succ_d, fail_q, fail_d, ice_q, ice_d;
  logic [SB-1:0] sum_q, sum_d;
  logic [MB-1:0] mean_q;
  logic [2:0]    ev_d, ev_q;
  logic          acc_d, acc_q;

  // Divider state: restoring, one quotient bit per cycle.
  logic [SB-1:0] dquo_q;
  logic [CB:0]   drem_q;
  logic [NB-1:0] dcnt_q;

  // Combinational decode of the held item.
  logic          tick_end, tick_rem_zero;
  logic [DB-1:0] rem_dec;
  logic          do_attempt, do_fail;
  logic [7:0]    att_base;
  logic [PB-1:0] prod_base;
  logic [DB-1:0] delay_calc;
  logic [DB+8:0] lin_prod;
  logic [PB-1:0] prod_shr;
  logic [PB+12-1:0] mul_full;
  logic [PB+12-9:0] mul_shr;
  logic [SB:0]   sum_add;

  function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] v);
    sat_inc = (&v) ? v : v + 1'b1;
  endfunction

  always_comb begin
    rem_dec       = (rem_q != '0) ? rem_q - 1'b1 : rem_q;
    tick_rem_zero = (rem_dec == '0);
    tick_end      = (item_q.func == rbc_pkg::FuncTick) && rec_q && tick_rem_zero;
    sts_o.need_mul = tick_end && (link_q != rbc_pkg::LsConnected);
    sts_o.need_div = tick_end && (link_q == rbc_pkg::LsConnected);
    sts_o.div_last = (dcnt_q == NB'(SB - 1));
  end

  assign mul_full = prod_q * cfg_q.backoff_factor;
  assign mul_shr  = mul_full[PB+12-1:8];

  always_comb begin
    att_base  = sts_o.need_mul ? ((&att_q) ? att_q : att_q + 1'b1) : 8'd0;
    prod_base = sts_o.need_mul ? newprod_q : {{(PB-24){1'b0}}, cfg_q.initial_delay_ms, 8'd0};
    prod_shr  = prod_base >> 8;
    lin_prod  = cfg_q.initial_delay_ms * ({1'b0, att_base} + 9'd1);
    case (cfg_q.strategy)
      rbc_pkg::StratImmediate: delay_calc = DB'(cfg_q.initial_delay_ms);
      rbc_pkg::StratLinear: delay_calc = (|lin_prod[DB+8:DB]) ? '1 : lin_prod[DB-1:0];
      rbc_pkg::StratExp: delay_calc = (prod_shr > PB'(cfg_q.max_delay_ms)) ?
                                      cfg_q.max_delay_ms : prod_shr[DB-1:0];
      default: delay_calc = '0;
    endcase
  end

  always_comb begin
    link_d = link_q; rec_d = rec_q; att_d = att_q; delay_d = delay_q; rem_d = rem_q;
    prod_d = prod_q; down_d = down_q; disc_d = disc_q; succ_d = succ_q;
    fail_d = fail_q; ice_d = ice_q; sum_d = sum_q;
    ev_d = rbc_pkg::EvNone; acc_d = 1'b0;
    do_attempt = 1'b0; do_fail = 1'b0;
    sum_add = {1'b0, sum_q} + (SB+1)'(down_q);
    case (item_q.func)
      rbc_pkg::FuncTick: begin
        down_d = (&down_q) ? down_q : down_q + 1'b1;
        if (rec_q) begin
          rem_d = rem_dec;
          if (tick_rem_zero) begin
            if (link_q == rbc_pkg::LsConnected) begin
              // The downtime of this tick is part of the recovery.
              sum_add = {1'b0, sum_q} + (SB+1)'(down_d);
              succ_d = sat_inc(succ_q);
              sum_d  = sum_add[SB] ? '1 : sum_add[SB-1:0];
              rec_d  = 1'b0;
              ev_d   = rbc_pkg::EvDone;
            end else begin
              att_d  = att_base;
              prod_d = newprod_q;
              do_attempt = 1'b1;
            end
          end
        end
      end
      rbc_pkg::FuncState: begin
        if (link_q == rbc_pkg::LsConnected &&
            item_q.new_link_state == rbc_pkg::LsDisconnected) begin
          disc_d = sat_inc(disc_q);
          down_d = '0;
          ev_d   = rbc_pkg::EvDisc;
        end
        link_d = item_q.new_link_state;
      end
      rbc_pkg::FuncNet: begin
        if (item_q.net_up && cfg_q.ice_restart_enable) begin
          ice_d = sat_inc(ice_q);
          ev_d  = rbc_pkg::EvIce;
        end
      end
      rbc_pkg::FuncStart: begin
        if (cfg_q.strategy != rbc_pkg::StratNone && !rec_q) begin
          acc_d  = 1'b1;
          att_d  = 8'd0;
          rec_d  = 1'b1;
          prod_d = prod_base;
          do_attempt = 1'b1;
        end
      end
      rbc_pkg::FuncCancel: begin
        if (rec_q) do_fail = 1'b1;
      end
      rbc_pkg::FuncReconn: link_d = rbc_pkg::LsConnected;
      default: ;
    endcase
    if (do_attempt) begin
      if (att_d < cfg_q.attempt_limit) begin
        delay_d = delay_calc;
        rem_d   = delay_calc;
        link_d  = rbc_pkg::LsReconnecting;
        ev_d    = rbc_pkg::EvRecon;
      end else begin
        do_fail = 1'b1;
      end
    end
    if (do_fail) begin
      link_d = rbc_pkg::LsFailed;
      fail_d = sat_inc(fail_q);
      rec_d  = 1'b0;
      ev_d   = rbc_pkg::EvFailed;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) item_q <= item_i;
    if (cmd_i.mul) newprod_q <= (|mul_shr[PB+12-9:PB]) ? '1 : mul_shr[PB-1:0];
  end

  logic [CB:0] trial;
  assign trial = {drem_q[CB-1:0], dquo_q[SB-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{strategy: rbc_pkg::StratExp, initial_delay_ms: 16'd1000,
                 max_delay_ms: DB'(30000), backoff_factor: 12'd512, attempt_limit: 8'd10,
                 ice_restart_enable: 1'b1};
      link_q <= '0; rec_q <= 1'b0; att_q <= '0; delay_q <= DB'(1000); rem_q <= '0;
      prod_q <= '0; down_q <= '0; disc_q <= '0; succ_q <= '0; fail_q <= '0;
      ice_q <= '0; sum_q <= '0; mean_q <= '0; ev_q <= rbc_pkg::EvNone; acc_q <= 1'b0;
      dquo_q <= '0; drem_q <= '0; dcnt_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          rbc_pkg::RegStrategy: cfg_q.strategy         <= cfg_data_i[1:0];
          rbc_pkg::RegInitial:  cfg_q.initial_delay_ms <= cfg_data_i[15:0];
          rbc_pkg::RegMax:      cfg_q.max_delay_ms     <= cfg_data_i[DB-1:0];
          rbc_pkg::RegFactor:   cfg_q.backoff_factor   <= cfg_data_i[11:0];
          rbc_pkg::RegLimit:    cfg_q.attempt_limit    <= cfg_data_i[7:0];
          rbc_pkg::RegIce:      cfg_q.ice_restart_enable <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (cmd_i.step) begin
        link_q <= link_d; rec_q <= rec_d; att_q <= att_d; delay_q <= delay_d;
        rem_q <= rem_d; prod_q <= prod_d; down_q <= down_d; disc_q <= disc_d;
        succ_q <= succ_d; fail_q <= fail_d; ice_q <= ice_d; sum_q <= sum_d;
        ev_q <= ev_d; acc_q <= acc_d;
      end
      if (cmd_i.div_start) begin
        dquo_q <= sum_q; drem_q <= '0; dcnt_q <= '0;
      end else if (cmd_i.div_step) begin
        // Shift in one dividend bit, subtract the success count if it fits.
        if (trial >= {1'b0, succ_q}) begin
          drem_q <= trial - {1'b0, succ_q};
          dquo_q <= {dquo_q[SB-2:0], 1'b1};
        end else begin
          drem_q <= trial;
          dquo_q <= {dquo_q[SB-2:0], 1'b0};
        end
        dcnt_q <= dcnt_q + 1'b1;
      end
      if (cmd_i.div_done) begin
        if (trial >= {1'b0, succ_q})
          mean_q <= (|dquo_q[SB-2:MB-1]) ? '1 : {dquo_q[MB-2:0], 1'b1};
        else
          mean_q <= (|dquo_q[SB-2:MB-1]) ? '1 : {dquo_q[MB-2:0], 1'b0};
      end
    end
  end

  assign res_o = '{event_res: ev_q, attempt_count: att_q, link_state: link_q,
                   recov_active: rec_q, start_accepted: acc_q, next_delay_ms: delay_q,
                   disconnect_total: disc_q, success_total: succ_q, failure_total: fail_q,
                   ice_restart_total: ice_q, downtime_total_ms: sum_q,
                   mean_recovery_ms: mean_q};
endmodule
`default_nettype wire

[design/reconnect_backoff_controller_top.sv]
// Top level of the reconnect backoff controller.
`timescale 1ns / 1ps
`default_nettype none
// One event beat in, one result beat out. An item passes the evaluate and
// output states; a retry adds the registered multiply of the exponential
// growth product, and a successful recovery adds the load and step states of
// the restoring divider that recomputes the mean recovery time, one quotient
// bit per cycle over the 40-bit downtime sum. One item is in work at a time;
// the next is taken after the result beat. Configuration writes land at once.
module reconnect_backoff_controller_top (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  rbc_if.sink                                  in_if,
  rbc_if.source                                out_if,
  input  wire logic                            cfg_we_i,
  input  wire logic [rbc_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  wire logic [rbc_pkg::CfgDataBits-1:0] cfg_data_i
);
  rbc_pkg::cmd_t cmd;
  rbc_pkg::sts_t sts;
  logic          in_ready;
  logic          out_valid;

  assign in_if.ready  = in_ready;
  assign out_if.valid = out_valid;

  rbc_ctrl u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_if.valid), .in_ready_o(in_ready),
    .out_valid_o(out_valid), .out_ready_i(out_if.ready), .sts_i(sts), .cmd_o(cmd)
  );

  rbc_dp u_dp (
    .clk_i(clk_i), .rst_ni(rst_ni), .load_i(in_if.valid && in_ready), .item_i(in_if.data),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i),
    .cmd_i(cmd), .sts_o(sts), .res_o(out_if.data)
  );

  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready && out_valid)) else $error("input and output active together");
  a_div_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_done |-> cmd.div_step) else $error("divider finished without a step");
  a_step_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.step |=> !cmd.step) else $error("event logic applied twice");
endmodule
`default_nettype wire

[bench/tb_reconnect_backoff_controller_top.sv]
// Self-checking testbench for the reconnect backoff controller top level.
`timescale 1ns / 1ps
`default_nettype none
module tb_reconnect_backoff_controller_top;

  localparam int unsigned IdleLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [rbc_pkg::CfgIdxBits-1:0] cfg_idx_i = '0;
  logic [rbc_pkg::CfgDataBits-1:0] cfg_data_i = '0;

  rbc_if #(.T(rbc_pkg::in_t)) in_if ();
  rbc_if #(.T(rbc_pkg::out_t)) out_if ();

  reconnect_backoff_controller_top u_top (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_if(in_if.sink),
    .out_if(out_if.source),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Controller configuration and state as the bench tracks it.
  rbc_pkg::cfg_t cfg;
  logic [2:0] m_link;
  logic m_recov;
  logic [7:0] m_attempt;
  logic [rbc_pkg::DelayBits-1:0] m_delay, m_remain;
  logic [rbc_pkg::ProdBits-1:0] m_growth;
  logic [rbc_pkg::TickBits-1:0] m_down;
  logic [rbc_pkg::CountBits-1:0] m_disc, m_succ, m_fail, m_ice;
  logic [rbc_pkg::SumBits-1:0] m_sum;
  logic [rbc_pkg::MeanBits-1:0] m_mean;

  rbc_pkg::out_t pending_results[$];
  int errors = 0;
  int idle_cycles = 0;
  bit long_hold = 1'b0;
  bit stall_on = 1'b1;

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
  end

  function automatic logic [rbc_pkg::DelayBits-1:0] retry_delay();
    logic [63:0] d;
    case (cfg.strategy)
      rbc_pkg::StratImmediate: d = 64'(cfg.initial_delay_ms);
      rbc_pkg::StratLinear: d = 64'(cfg.initial_delay_ms) * (64'(m_attempt) + 64'd1);
      rbc_pkg::StratExp: begin
        d = 64'(m_growth) >> 8;
        if (d > 64'(cfg.max_delay_ms)) d = 64'(cfg.max_delay_ms);
      end
      default: d = 64'd0;
    endcase
    return (d > 64'hFF_FFFF) ? 24'hFF_FFFF : d[rbc_pkg::DelayBits-1:0];
  endfunction

  function automatic logic [rbc_pkg::CountBits-1:0] sat_up(
      logic [rbc_pkg::CountBits-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic [2:0] give_up();
    m_link = rbc_pkg::LsFailed;
    m_fail = sat_up(m_fail);
    m_recov = 1'b0;
    return rbc_pkg::EvFailed;
  endfunction

  function automatic logic [2:0] next_attempt();
    if (m_attempt < cfg.attempt_limit) begin
      m_delay = retry_delay();
      m_remain = m_delay;
      m_link = rbc_pkg::LsReconnecting;
      return rbc_pkg::EvRecon;
    end
    return give_up();
  endfunction

  function automatic logic [2:0] tick_event();
    logic [63:0] p;
    logic [rbc_pkg::SumBits:0] s;
    logic [rbc_pkg::SumBits-1:0] q;
    if (!(&m_down)) m_down = m_down + 1'b1;
    if (!m_recov) return rbc_pkg::EvNone;
    if (m_remain != 0) m_remain = m_remain - 1'b1;
    if (m_remain != 0) return rbc_pkg::EvNone;
    if (m_link == rbc_pkg::LsConnected) begin
      m_succ = sat_up(m_succ);
      s = {1'b0, m_sum} + (rbc_pkg::SumBits + 1)'(m_down);
      m_sum = s[rbc_pkg::SumBits] ? '1 : s[rbc_pkg::SumBits-1:0];
      q = (m_succ != 0) ? m_sum / (rbc_pkg::SumBits)'(m_succ) : '0;
      m_mean = (q > 40'hFFFF_FFFF) ? '1 : q[rbc_pkg::MeanBits-1:0];
      m_recov = 1'b0;
      return rbc_pkg::EvDone;
    end
    if (m_attempt != 8'hFF) m_attempt = m_attempt + 1'b1;
    p = (64'(m_growth) * 64'(cfg.backoff_factor)) >> 8;
    m_growth = (p > 64'hFFFF_FFFF) ? '1 : p[rbc_pkg::ProdBits-1:0];
    return next_attempt();
  endfunction

  function automatic rbc_pkg::out_t predict_result(rbc_pkg::in_t it);
    rbc_pkg::out_t r;
    logic [2:0] ev;
    logic ok;
    ev = rbc_pkg::EvNone;
    ok = 1'b0;
    case (it.func)
      rbc_pkg::FuncTick: ev = tick_event();
      rbc_pkg::FuncState: begin
        if (m_link == rbc_pkg::LsConnected &&
            it.new_link_state == rbc_pkg::LsDisconnected) begin
          m_disc = sat_up(m_disc);
          m_down = '0;
          ev = rbc_pkg::EvDisc;
        end
        m_link = it.new_link_state;
      end
      rbc_pkg::FuncNet: begin
        if (it.net_up && cfg.ice_restart_enable) begin
          m_ice = sat_up(m_ice);
          ev = rbc_pkg::EvIce;
        end
      end
      rbc_pkg::FuncStart: begin
        if (cfg.strategy != rbc_pkg::StratNone && !m_recov) begin
          ok = 1'b1;
          m_attempt = '0;
          m_recov = 1'b1;
          m_growth = (rbc_pkg::ProdBits)'(cfg.initial_delay_ms) << 8;
          ev = next_attempt();
        end
      end
      rbc_pkg::FuncCancel: if (m_recov) ev = give_up();
      rbc_pkg::FuncReconn: m_link = rbc_pkg::LsConnected;
      default: ;
    endcase
    r.event_res = ev;
    r.attempt_count = m_attempt;
    r.link_state = m_link;
    r.recov_active = m_recov;
    r.start_accepted = ok;
    r.next_delay_ms = m_delay;
    r.disconnect_total = m_disc;
    r.success_total = m_succ;
    r.failure_total = m_fail;
    r.ice_restart_total = m_ice;
    r.downtime_total_ms = m_sum;
    r.mean_recovery_ms = m_mean;
    return r;
  endfunction

  // Receiver: stalls on a rotating pattern with random gaps, holds off for a long stretch, or is always ready.
  initial begin
    int phase;
    phase = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      phase = phase + 1;
      if (long_hold) out_if.ready <= 1'b0;
      else if (!stall_on) out_if.ready <= 1'b1;
      else out_if.ready <= (phase % 7 != 3) && ($urandom_range(0, 3) != 0);
    end
  end

  // Result checker and watchdog.
  always @(posedge clk_i) begin
    rbc_pkg::out_t got, want;
    if (in_if.valid && in_if.ready || out_if.valid && out_if.ready) idle_cycles = 0;
    else if (rst_ni) idle_cycles = idle_cycles + 1;
    if (idle_cycles >= IdleLimit && !long_hold) begin
      $display("CHECK FAILED");
      $finish;
    end
    if (out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected");
        errors = errors + 1;
      end else begin
        want = pending_results.pop_front();
        if (got.event_res !== want.event_res) begin
          $error("event_res exp %0d got %0d", want.event_res, got.event_res);
          errors++;
        end
        if (got.attempt_count !== want.attempt_count) begin
          $error("attempt_count exp %0d got %0d", want.attempt_count, got.attempt_count);
          errors++;
        end
        if (got.link_state !== want.link_state) begin
          $error("link_state exp %0d got %0d", want.link_state, got.link_state);
          errors++;
        end
        if (got.recov_active !== want.recov_active) begin
          $error("recov_active exp %0d got %0d", want.recov_active, got.recov_active);
          errors++;
        end
        if (got.start_accepted !== want.start_accepted) begin
          $error("start_accepted exp %0d got %0d", want.start_accepted,
                 got.start_accepted);
          errors++;
        end
        if (got.next_delay_ms !== want.next_delay_ms) begin
          $error("next_delay_ms exp %0d got %0d", want.next_delay_ms, got.next_delay_ms);
          errors++;
        end
        if (got.disconnect_total !== want.disconnect_total) begin
          $error("disconnect_total exp %0d got %0d", want.disconnect_total,
                 got.disconnect_total);
          errors++;
        end
        if (got.success_total !== want.success_total) begin
          $error("success_total exp %0d got %0d", want.success_total, got.success_total);
          errors++;
        end
        if (got.failure_total !== want.failure_total) begin
          $error("failure_total exp %0d got %0d", want.failure_total, got.failure_total);
          errors++;
        end
        if (got.ice_restart_total !== want.ice_restart_total) begin
          $error("ice_restart_total exp %0d got %0d", want.ice_restart_total,
                 got.ice_restart_total);
          errors++;
        end
        if (got.downtime_total_ms !== want.downtime_total_ms) begin
          $error("downtime_total_ms exp %0d got %0d", want.downtime_total_ms,
                 got.downtime_total_ms);
          errors++;
        end
        if (got.mean_recovery_ms !== want.mean_recovery_ms) begin
          $error("mean_recovery_ms exp %0d got %0d", want.mean_recovery_ms,
                 got.mean_recovery_ms);
          errors++;
        end
      end
    end
  end

  int burst_left = 0;

  // Offers one beat and waits for it to be taken; the valid stays high
  // across back-to-back beats of a burst.
  task automatic send_event(logic [2:0] func, logic [2:0] nls, logic conn);
    rbc_pkg::in_t it;
    int gap;
    it.func = func;
    it.new_link_state = nls;
    it.net_up = conn;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 4);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_if.valid <= 1'b1;
    in_if.data <= it;
    do @(posedge clk_i); while (!in_if.ready);
    pending_results.push_back(predict_result(it));
    burst_left = burst_left - 1;
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [rbc_pkg::CfgIdxBits-1:0] idx,
                           logic [rbc_pkg::CfgDataBits-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      rbc_pkg::RegStrategy: cfg.strategy = val[1:0];
      rbc_pkg::RegInitial: cfg.initial_delay_ms = val[15:0];
      rbc_pkg::RegMax: cfg.max_delay_ms = val;
      rbc_pkg::RegFactor: cfg.backoff_factor = val[11:0];
      rbc_pkg::RegLimit: cfg.attempt_limit = val[7:0];
      rbc_pkg::RegIce: cfg.ice_restart_enable = val[0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [1:0] strat, logic [15:0] init, logic [23:0] maxd,
                            logic [11:0] fac, logic [7:0] lim, logic ice);
    write_reg(rbc_pkg::RegStrategy, (rbc_pkg::CfgDataBits)'(strat));
    write_reg(rbc_pkg::RegInitial, (rbc_pkg::CfgDataBits)'(init));
    write_reg(rbc_pkg::RegMax, maxd);
    write_reg(rbc_pkg::RegFactor, (rbc_pkg::CfgDataBits)'(fac));
    write_reg(rbc_pkg::RegLimit, (rbc_pkg::CfgDataBits)'(lim));
    write_reg(rbc_pkg::RegIce, (rbc_pkg::CfgDataBits)'(ice));
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_event(rbc_pkg::FuncTick, 3'($urandom), 1'($urandom));
  endtask

  // Extremes of every field and each operation, with the reset settings and then with zeroed and changed settings.
  task automatic test_directed();
    send_event(rbc_pkg::FuncTick, 3'd7, 1'b1);
    send_event(rbc_pkg::FuncReconn, 3'd0, 1'b0);
    send_event(rbc_pkg::FuncState, rbc_pkg::LsDisconnected, 1'b0);
    send_event(rbc_pkg::FuncNet, 3'd0, 1'b1);
    send_event(rbc_pkg::FuncNet, 3'd7, 1'b0);
    send_event(rbc_pkg::FuncCancel, 3'd0, 1'b0);
    send_event(3'd6, 3'd7, 1'b1);
    send_event(3'd7, 3'd0, 1'b0);
    send_event(rbc_pkg::FuncState, 3'd7, 1'b1);
    send_event(rbc_pkg::FuncStart, 3'd0, 1'b0);
    send_event(rbc_pkg::FuncStart, 3'd0, 1'b0);
    send_event(rbc_pkg::FuncCancel, 3'd0, 1'b0);
    drain_results();
    set_config(rbc_pkg::StratNone, 16'd0, 24'd0, 12'd0, 8'd0, 1'b0);
    send_event(rbc_pkg::FuncStart, 3'd0, 1'b0);
    send_event(rbc_pkg::FuncNet, 3'd0, 1'b1);
    drain_results();
    // Zero-delay immediate retries and a limit of zero.
    write_reg(rbc_pkg::RegStrategy, (rbc_pkg::CfgDataBits)'(rbc_pkg::StratImmediate));
    send_event(rbc_pkg::FuncStart, 3'd0, 1'b0);
    send_event(rbc_pkg::FuncReconn, 3'd0, 1'b0);
    drain_results();
    write_reg(rbc_pkg::RegLimit, 24'd3);
    send_event(rbc_pkg::FuncState, 3'd0, 1'b0);
    send_event(rbc_pkg::FuncStart, 3'd0, 1'b0);
    send_ticks(5);
    drain_results();
  endtask

  // A recovery sequence with random content, mostly well formed.
  task automatic recovery_run();
    int n;
    send_event(rbc_pkg::FuncReconn, 3'd0, 1'b0);
    send_event(rbc_pkg::FuncState, rbc_pkg::LsDisconnected, 1'b0);
    send_event(rbc_pkg::FuncStart, 3'($urandom), 1'($urandom));
    n = $urandom_range(1, 12);
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 15))
        0: send_event(rbc_pkg::FuncReconn, 3'($urandom), 1'($urandom));
        1: send_event(rbc_pkg::FuncState, 3'($urandom), 1'($urandom));
        2: send_event(rbc_pkg::FuncNet, 3'($urandom), 1'($urandom));
        3: send_event(3'($urandom), 3'($urandom), 1'($urandom));
        default: send_event(rbc_pkg::FuncTick, 3'($urandom), 1'($urandom));
      endcase
    end
    if ($urandom_range(0, 5) == 0) send_event(rbc_pkg::FuncCancel, 3'd0, 1'b0);
  endtask

  task automatic test_random_phase(logic [1:0] strat, logic [15:0] init,
                                   logic [23:0] maxd, logic [11:0] fac,
                                   logic [7:0] lim, logic ice, int runs);
    set_config(strat, init, maxd, fac, lim, ice);
    repeat (runs) recovery_run();
    drain_results();
  endtask

  // The receiver holds off while items keep coming, then items are sent with the receiver always ready.
  task automatic test_backpressure();
    fork
      begin
        long_hold = 1'b1;
        repeat (300) @(negedge clk_i);
        long_hold = 1'b0;
      end
      send_ticks(20);
    join
    drain_results();
    stall_on = 1'b0;
    send_ticks(30);
    drain_results();
    stall_on = 1'b1;
  endtask

  initial begin
    cfg.strategy = rbc_pkg::StratExp;
    cfg.initial_delay_ms = 16'd1000;
    cfg.max_delay_ms = 24'd30000;
    cfg.backoff_factor = 12'd512;
    cfg.attempt_limit = 8'd10;
    cfg.ice_restart_enable = 1'b1;
    m_link = 3'd0;
    m_recov = 1'b0;
    m_attempt = '0;
    m_delay = 24'd1000;
    m_remain = '0;
    m_growth = '0;
    m_down = '0;
    m_disc = '0;
    m_succ = '0;
    m_fail = '0;
    m_ice = '0;
    m_sum = '0;
    m_mean = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_backpressure();
    test_random_phase(rbc_pkg::StratImmediate, 16'd2, 24'd5, 12'd256, 8'd4, 1'b1, 20);
    test_random_phase(rbc_pkg::StratLinear, 16'd1, 24'd100, 12'd300, 8'd3, 1'b0, 20);
    test_random_phase(rbc_pkg::StratExp, 16'd1, 24'd6, 12'd512, 8'd5, 1'b1, 20);
    test_random_phase(rbc_pkg::StratExp, 16'd3, 24'd0, 12'hFFF, 8'd255, 1'b1, 10);
    test_random_phase(rbc_pkg::StratExp, 16'hFFFF, 24'hFFFFFF, 12'hFFF, 8'd1, 1'b1, 2);
    test_random_phase(rbc_pkg::StratLinear, 16'hFFFF, 24'hFFFFFF, 12'd0, 8'd0, 1'b0, 10);
    test_random_phase(rbc_pkg::StratExp, 16'd2, 24'd3, 12'd0, 8'd6, 1'b1, 10);
    test_random_phase(rbc_pkg::StratImmediate, 16'd0, 24'd0, 12'd1, 8'd2, 1'b1, 9);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

[reconnect_backoff_controller_top.f]
design/rbc_pkg.sv
design/rbc_if.sv
design/rbc_ctrl.sv
design/rbc_dp.sv
design/reconnect_backoff_controller_top.sv
bench/tb_reconnect_backoff_controller_top.sv
